### design/rac_pkg.sv
// Shared types, constants and the CORDIC elementary-angle table for the roll angle guard.
// Used by rac_cordic, roll_angle_capsize_guard_unit, roll_guard_checker and tb_top; depends on nothing else.
package rac_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int VEC_GUARD_BITS  = 20;
   localparam int SAMPLE_W        = 16;
   localparam int VEC_W           = SAMPLE_W + VEC_GUARD_BITS + 4;
   localparam int VEC_PAD         = VEC_W - SAMPLE_W - 1 - VEC_GUARD_BITS;
   localparam int ACC_W           = ANGLE_FRAC_BITS + 10;
   localparam int ATAN_ENTRIES    = 32;
   localparam int CORDIC_ITERS    = (ANGLE_FRAC_BITS + 4 > ATAN_ENTRIES) ?
                                    ATAN_ENTRIES : ANGLE_FRAC_BITS + 4;
   localparam int ANGLE_W         = 9;
   localparam int CRIT_W          = 8;

   localparam logic [CRIT_W-1:0] CRIT_ANGLE_RESET = 8'd45;

   localparam longint unsigned PICO_DEG = 64'd1000000000000;

   localparam longint unsigned ATAN_PICO_DEG [ATAN_ENTRIES] = '{
      64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
      64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
      64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
      64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
      64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
      64'd54641513,       64'd27320757,       64'd13660378,       64'd6830189,
      64'd3415095,        64'd1707547,        64'd853774,         64'd426887,
      64'd213443,         64'd106722,         64'd53361,          64'd26680
   };

   typedef struct packed {
      logic signed [VEC_W-1:0]   x;
      logic signed [VEC_W-1:0]   y;
      logic signed [ACC_W-1:0]   acc;
      logic                      special;
      logic signed [ANGLE_W-1:0] special_angle;
   } vec_type;

   // Elementary angle atan(2^-i) in units of 2^-ANGLE_FRAC_BITS degree, rounded half up.
   function automatic logic [ACC_W-1:0] elem_angle(input int idx);
      longint unsigned e;
      longint unsigned q;
      longint unsigned r;
      longint unsigned v;
      e = ATAN_PICO_DEG[idx];
      q = e / PICO_DEG;
      r = e % PICO_DEG;
      v = (q << ANGLE_FRAC_BITS) + ((r << ANGLE_FRAC_BITS) + PICO_DEG / 2) / PICO_DEG;
      return v[ACC_W-1:0];
   endfunction

endpackage

### design/rac_cordic.sv
// Pipelined CORDIC vectoring core, one register stage per iteration with per-stage valid bits.
// Depends on rac_pkg for the vector type, widths and elementary-angle table.
module rac_cordic import rac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  vec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output vec_type out_data
);

   logic [CORDIC_ITERS-1:0] vld_ff;
   vec_type                 data_ff [CORDIC_ITERS];
   logic [CORDIC_ITERS:0]   rdy;

   assign rdy[CORDIC_ITERS] = out_ready;
   assign in_ready          = rdy[0];

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      localparam logic signed [ACC_W-1:0] ELEM = elem_angle(i);

      vec_type                 src;
      logic                    src_vld;
      vec_type                 stage_in;
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;

      if (i == 0) begin : g_head
         assign src     = in_data;
         assign src_vld = in_valid;
      end else begin : g_body
         assign src     = data_ff[i-1];
         assign src_vld = vld_ff[i-1];
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      always_comb begin
         xs       = $signed(src.x) >>> i;
         ys       = $signed(src.y) >>> i;
         stage_in = src;
         if (!src.y[VEC_W-1]) begin
            stage_in.x   = src.x + ys;
            stage_in.y   = src.y - xs;
            stage_in.acc = src.acc + ELEM;
         end else begin
            stage_in.x   = src.x - ys;
            stage_in.y   = src.y + xs;
            stage_in.acc = src.acc - ELEM;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i] && src_vld) begin
            data_ff[i] <= stage_in;
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_ITERS-1];
   assign out_data  = data_ff[CORDIC_ITERS-1];

endmodule

### design/roll_angle_capsize_guard_unit.sv
// Top level of the roll angle capsize guard: input stage, CORDIC core, result stage, register.
// Depends on rac_pkg and rac_cordic.
//
// A sample (req_accel_y, req_accel_z) is taken on a req_ transfer. The block computes the roll
// angle atan2(y, z) in whole degrees, truncated toward zero, and returns it on rsp_roll_angle
// together with rsp_release_sails, which is set when the angle magnitude exceeds the critical
// angle. Every sample gives exactly one result, in order.
// The critical angle is written by a csr_ transfer; csr_ready is always high. Write it only
// while no sample is in flight.
// A req_ transfer loads the input stage; then one stage for each of the 20 CORDIC iterations
// and one result stage follow before rsp_valid. A new sample can be taken every cycle while
// the receiver keeps up, so sustained throughput is one sample per cycle, set by the iteration
// pipeline.
// Each stage carries its own valid bit. When the receiver stalls, stages fill up behind the
// result register while empty stages keep accepting, and nothing is lost or repeated; once
// every stage is full, req_ready drops until the receiver takes a result.
// Synchronous reset empties the pipeline and sets the critical angle to 45 degrees.
module roll_angle_capsize_guard_unit import rac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ANGLE_W-1:0]  rsp_roll_angle,
   output logic                       rsp_release_sails,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [CRIT_W-1:0]   csr_critical_angle
);

   localparam logic signed [ACC_W-1:0] ACC_90 = ACC_W'(90) <<< ANGLE_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] DEG_MAX = ACC_W'(180);

   logic [CRIT_W-1:0] crit_ff;

   logic                      in_vld_ff;
   vec_type                   in_data_ff;
   vec_type                   in_data_in;
   logic                      in_rdy;
   logic signed [SAMPLE_W:0]  ay;
   logic signed [SAMPLE_W:0]  az;
   logic signed [SAMPLE_W:0]  xr;
   logic signed [SAMPLE_W:0]  yr;

   logic                      core_in_ready;
   logic                      core_out_valid;
   vec_type                   core_out_data;
   logic                      out_rdy;

   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic                      sails_ff;
   logic signed [ANGLE_W-1:0] angle_in;
   logic                      sails_in;
   logic signed [ACC_W-1:0]   acc_mag;
   logic signed [ACC_W-1:0]   deg;
   logic        [ANGLE_W-1:0] mag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_ff <= CRIT_ANGLE_RESET;
      end else if (csr_valid) begin
         crit_ff <= csr_critical_angle;
      end
   end

   always_comb begin
      ay = {req_accel_y[SAMPLE_W-1], req_accel_y};
      az = {req_accel_z[SAMPLE_W-1], req_accel_z};
      in_data_in = '0;
      xr = az;
      yr = ay;
      if (az[SAMPLE_W]) begin
         if (!ay[SAMPLE_W]) begin
            xr             = ay;
            yr             = -az;
            in_data_in.acc = ACC_90;
         end else begin
            xr             = -ay;
            yr             = az;
            in_data_in.acc = -ACC_90;
         end
      end
      in_data_in.x = {{VEC_PAD{xr[SAMPLE_W]}}, xr, {VEC_GUARD_BITS{1'b0}}};
      in_data_in.y = {{VEC_PAD{yr[SAMPLE_W]}}, yr, {VEC_GUARD_BITS{1'b0}}};
      if (ay == '0) begin
         in_data_in.special       = 1'b1;
         in_data_in.special_angle = az[SAMPLE_W] ? 9'sd180 : 9'sd0;
      end else if (az == '0) begin
         in_data_in.special       = 1'b1;
         in_data_in.special_angle = ay[SAMPLE_W] ? -9'sd90 : 9'sd90;
      end else if (ay == az || ay == -az) begin
         in_data_in.special = 1'b1;
         if (az[SAMPLE_W]) begin
            in_data_in.special_angle = ay[SAMPLE_W] ? -9'sd135 : 9'sd135;
         end else begin
            in_data_in.special_angle = ay[SAMPLE_W] ? -9'sd45 : 9'sd45;
         end
      end
   end

   assign in_rdy    = !in_vld_ff || core_in_ready;
   assign req_ready = in_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_rdy) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && req_valid) begin
         in_data_ff <= in_data_in;
      end
   end

   rac_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .in_ready  (core_in_ready),
      .in_data   (in_data_ff),
      .out_valid (core_out_valid),
      .out_ready (out_rdy),
      .out_data  (core_out_data)
   );

   always_comb begin
      if (!core_out_data.acc[ACC_W-1]) begin
         acc_mag = core_out_data.acc >>> ANGLE_FRAC_BITS;
         deg     = acc_mag;
      end else begin
         acc_mag = (-core_out_data.acc) >>> ANGLE_FRAC_BITS;
         deg     = -acc_mag;
      end
      if (deg > DEG_MAX) begin
         deg = DEG_MAX;
      end else if (deg < -DEG_MAX) begin
         deg = -DEG_MAX;
      end
      angle_in = core_out_data.special ? core_out_data.special_angle : deg[ANGLE_W-1:0];
      mag      = angle_in[ANGLE_W-1] ? ANGLE_W'(-angle_in) : ANGLE_W'(angle_in);
      sails_in = mag > {1'b0, crit_ff};
   end

   assign out_rdy = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= core_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && core_out_valid) begin
         angle_ff <= angle_in;
         sails_ff <= sails_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = angle_ff;
   assign rsp_release_sails = sails_ff;

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_roll_angle) <= 9'sd180 && $signed(rsp_roll_angle) >= -9'sd180))
      else $error("roll angle outside -180..180");

   a_sails_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_sails |-> rsp_roll_angle != '0)
      else $error("release flag raised for a level angle");

   a_crit_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> crit_ff == CRIT_ANGLE_RESET)
      else $error("critical angle not restored by reset");

endmodule

### test/roll_guard_checker.sv
// Checker for the roll angle capsize guard: watches the sample, result and register channels,
// predicts each roll angle and release flag with its own CORDIC, and compares in order.
// Depends on rac_pkg for the port widths only.
module roll_guard_checker import rac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [ANGLE_W-1:0]  rsp_roll_angle,
   input  logic                       rsp_release_sails,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic        [CRIT_W-1:0]   csr_critical_angle,
   output int                         fail_count,
   output int                         outstanding
);

   localparam int FRAC_BITS    = 16;
   localparam int SCALE_BITS   = 20;
   localparam int CORDIC_STEPS = FRAC_BITS + 4;
   localparam longint unsigned PDEG_PER_DEG = 64'd1000000000000;

   // atan(2^-i) in picodegrees.
   localparam longint unsigned ATAN_STEP_PDEG [CORDIC_STEPS] = '{
      64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
      64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
      64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
      64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
      64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027
   };

   typedef struct {
      logic signed [ANGLE_W-1:0] roll;
      logic                      sails;
   } roll_result_type;

   roll_result_type   expected_rolls [$];
   logic [CRIT_W-1:0] critical_deg;

   function automatic longint step_angle(input int i);
      longint unsigned whole;
      longint unsigned part;
      whole = ATAN_STEP_PDEG[i] / PDEG_PER_DEG;
      part  = ATAN_STEP_PDEG[i] % PDEG_PER_DEG;
      return longint'((whole << FRAC_BITS) +
                      ((part << FRAC_BITS) + PDEG_PER_DEG / 2) / PDEG_PER_DEG);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] predict_roll(
      input logic signed [SAMPLE_W-1:0] ay,
      input logic signed [SAMPLE_W-1:0] az
   );
      longint sy;
      longint sz;
      longint x;
      longint y;
      longint t;
      longint xs;
      longint ys;
      longint acc;
      longint deg;
      sy  = ay;
      sz  = az;
      acc = 0;
      if (sy == 0) begin
         deg = (sz < 0) ? 180 : 0;
      end else if (sz == 0) begin
         deg = (sy > 0) ? 90 : -90;
      end else if (sy == sz || sy == -sz) begin
         deg = (sz > 0) ? 45 : 135;
         if (sy < 0) begin
            deg = -deg;
         end
      end else begin
         x = sz <<< SCALE_BITS;
         y = sy <<< SCALE_BITS;
         // Turn a vector in the left half plane by a quarter so that x starts positive.
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x   = y;
               y   = -t;
               acc = 64'sd90 <<< FRAC_BITS;
            end else begin
               x   = -y;
               y   = t;
               acc = -(64'sd90 <<< FRAC_BITS);
            end
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x   = x + ys;
               y   = y - xs;
               acc = acc + step_angle(i);
            end else begin
               x   = x - ys;
               y   = y + xs;
               acc = acc - step_angle(i);
            end
         end
         deg = (acc >= 0) ? (acc >>> FRAC_BITS) : -((-acc) >>> FRAC_BITS);
         if (deg > 180) begin
            deg = 180;
         end
         if (deg < -180) begin
            deg = -180;
         end
      end
      return deg[ANGLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) begin
         $display("mismatch: %s", msg);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      roll_result_type want;
      int              mag;
      if (reset) begin
         critical_deg = 8'd45;
         fail_count   = 0;
         expected_rolls.delete();
      end else begin
         if (req_valid && req_ready) begin
            want.roll  = predict_roll(req_accel_y, req_accel_z);
            mag        = want.roll;
            mag        = (mag < 0) ? -mag : mag;
            want.sails = (mag > int'(critical_deg));
            expected_rolls.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rolls.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, roll %0d",
                                         rsp_roll_angle));
            end else begin
               want = expected_rolls.pop_front();
               if (rsp_roll_angle !== want.roll) begin
                  report_mismatch($sformatf("roll_angle got %0d expected %0d",
                                            rsp_roll_angle, want.roll));
               end
               if (rsp_release_sails !== want.sails) begin
                  report_mismatch($sformatf("release_sails got %0b expected %0b (roll %0d)",
                                            rsp_release_sails, want.sails, want.roll));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            critical_deg = csr_critical_angle;
         end
      end
      outstanding <= expected_rolls.size();
   end

endmodule

### test/tb_top.sv
// Testbench top for roll_angle_capsize_guard_unit: clock, reset, sample and register stimulus,
// receiver stalls and the verdict. Depends on rac_pkg, the block and roll_guard_checker.
module tb_top;
   import rac_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int BATCH_ITEMS    = 108;
   localparam int DRAIN_CYCLES   = 30;

   logic                       clock              = 1'b0;
   logic                       reset              = 1'b1;
   logic                       req_valid          = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_accel_y        = '0;
   logic signed [SAMPLE_W-1:0] req_accel_z        = '0;
   logic                       rsp_valid;
   logic                       rsp_ready          = 1'b0;
   logic signed [ANGLE_W-1:0]  rsp_roll_angle;
   logic                       rsp_release_sails;
   logic                       csr_valid          = 1'b0;
   logic                       csr_ready;
   logic        [CRIT_W-1:0]   csr_critical_angle = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 30;
   int recv_idle_pct = 58;
   int hold_requests = 0;
   int holds_served  = 0;
   int idle_cycles   = 0;

   int crit_plan [12] = '{0, 180, 255, -1, 30, 90, 181, -1, 1, 135, -1, 45};

   roll_angle_capsize_guard_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_roll_angle     (rsp_roll_angle),
      .rsp_release_sails  (rsp_release_sails),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_critical_angle (csr_critical_angle)
   );

   roll_guard_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_roll_angle     (rsp_roll_angle),
      .rsp_release_sails  (rsp_release_sails),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_critical_angle (csr_critical_angle),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   initial begin
      forever begin
         #1 clock = ~clock;
      end
   end

   // The receiver either stalls at random or, when asked, holds off for a long stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL roll_angle_capsize_guard_unit");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(
      input logic signed [SAMPLE_W-1:0] y,
      input logic signed [SAMPLE_W-1:0] z
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_y <= y;
      req_accel_z <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_critical(input logic [CRIT_W-1:0] value);
      wait_drained();
      csr_valid          <= 1'b1;
      csr_critical_angle <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] corner_value();
      case ($urandom_range(4))
         0:       return -16'sd32768;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   task automatic send_random_sample();
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
      int                         mag;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            y = SAMPLE_W'($urandom());
            z = SAMPLE_W'($urandom());
         end
         4, 5: begin
            y = SAMPLE_W'(int'($urandom_range(600)) - 300);
            z = SAMPLE_W'(int'($urandom_range(600)) - 300);
         end
         6: begin
            if ($urandom_range(1)) begin
               y = 0;
               z = SAMPLE_W'($urandom());
            end else begin
               y = SAMPLE_W'($urandom());
               z = 0;
            end
         end
         7: begin
            mag = $urandom_range(32767, 1);
            y   = $urandom_range(1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
            z   = $urandom_range(1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
         end
         default: begin
            y = corner_value();
            z = corner_value();
         end
      endcase
      send_sample(y, z);
   endtask

   initial begin
      int crit;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Axis-aligned, equal-magnitude, extreme and near-threshold samples at the reset setting.
      send_sample(0, 0);
      send_sample(0, 1234);
      send_sample(0, -1234);
      send_sample(0, -32768);
      send_sample(500, 0);
      send_sample(-500, 0);
      send_sample(-32768, 0);
      send_sample(77, 77);
      send_sample(77, -77);
      send_sample(-77, 77);
      send_sample(-77, -77);
      send_sample(-32768, -32768);
      send_sample(32767, -32767);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);
      send_sample(1, 32767);
      send_sample(-1, -32768);
      send_sample(32767, 1);
      send_sample(-32768, -1);
      send_sample(100, 99);
      send_sample(100, 95);
      send_sample(-100, 95);
      send_sample(12345, -23456);
      send_sample(-1, 1);

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < 4; s++) begin
            crit = crit_plan[regime * 4 + s];
            if (crit < 0) begin
               crit = $urandom_range(180);
            end
            write_critical(CRIT_W'(crit));
            if (regime == 2 && s == 0) begin
               hold_requests <= hold_requests + 1;
            end
            repeat (BATCH_ITEMS) send_random_sample();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS roll_angle_capsize_guard_unit");
      end else begin
         $display("FAIL roll_angle_capsize_guard_unit");
      end
      $finish;
   end

endmodule
